// ===== sv/bdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared constants, types and helpers for the block-diagonal times dense
// matrix multiply core.
// ----------------------------------------------------------------------------
package bdm_pkg;

  // Store geometry (power-of-two maxima give concatenated addresses)
  localparam int MAX_BLOCK_ROWS = 8;
  localparam int MAX_BLOCK_COLS = 8;
  localparam int MAX_BLOCKS     = 8;
  localparam int MAX_DENSE_COLS = 8;

  localparam int BLK_DEPTH = MAX_BLOCKS * MAX_BLOCK_ROWS * MAX_BLOCK_COLS;
  localparam int DNS_DEPTH = MAX_BLOCK_COLS * MAX_BLOCKS * MAX_DENSE_COLS;
  localparam int BLK_AW    = $clog2(BLK_DEPTH);
  localparam int DNS_AW    = $clog2(DNS_DEPTH);

  localparam int BIDX_W = $clog2(MAX_BLOCKS);
  localparam int BROW_W = $clog2(MAX_BLOCK_ROWS);
  localparam int BCOL_W = $clog2(MAX_BLOCK_COLS);
  localparam int DCOL_W = $clog2(MAX_DENSE_COLS);
  localparam int DROW_W = DNS_AW - DCOL_W;

  // Item field widths
  localparam int CMD_W = 2;
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int REG_W = 4;
  localparam int CFG_IDX_W = 2;

  // Arithmetic widths: exact sum of up to eight Q32.32 products
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_BLOCK = 2'd0,
    CMD_LOAD_DENSE = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_BAD        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_ROWS  = 2'd0,
    REG_BLOCK_COLS  = 2'd1,
    REG_BLOCK_COUNT = 2'd2,
    REG_DENSE_COLS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RUN,
    S_WAIT,
    S_PUSH
  } state_t;

  // Sequencer to MAC unit: controls aligned with the store read issue
  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } mac_ctl_t;

  // MAC unit to sequencer: rounded, saturated result
  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
  } mac_res_t;

  // Clamp a register to 1..maxv (zero reads as one)
  function automatic logic [REG_W-1:0] eff(input logic [REG_W-1:0] v,
                                           input logic [REG_W-1:0] maxv);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) r = REG_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== sv/bdm_if.sv =====
// ----------------------------------------------------------------------------
// bdm request / result channels
// Valid/ready channels carrying one request and one result of the core.
// ----------------------------------------------------------------------------
interface bdm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [2:0]         block_index;
  logic [5:0]         row_index;
  logic [5:0]         col_index;
  logic signed [31:0] element_value;

  modport source (output valid, cmd, block_index, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, cmd, block_index, row_index, col_index, element_value,
                  output ready);
endinterface

interface bdm_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] product_value;
  logic               status;

  modport source (output valid, product_value, status, input ready);
  modport sink   (input valid, product_value, status, output ready);
endinterface

// ===== sv/bdm_ram.sv =====
// ----------------------------------------------------------------------------
// bdm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bdm_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bdm_mac.sv =====
// ----------------------------------------------------------------------------
// bdm_mac
// Multiply-accumulate pipeline: multiply the two store words, accumulate
// exactly, then round to Q16.16 with saturation.
// ----------------------------------------------------------------------------
module bdm_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  bdm_pkg::mac_ctl_t         ctl,
  input  logic signed [31:0]        a_data,
  input  logic signed [31:0]        d_data,
  output bdm_pkg::mac_res_t         res
);
  import bdm_pkg::*;

  logic                     v1, l1, v2, l2, l3, done;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [VAL_W-1:0]  value;

  // Round half up by 2^15 and saturate to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0]    t;
    logic        [ACC_W-17:0]   s;
    logic        [ACC_W-17:31]  top;
    logic signed [VAL_W-1:0]    r;
    t   = x + ACC_W'(17'h08000);
    s   = t[ACC_W-1:16];
    top = s[ACC_W-17:31];
    if ((&top) || !(|top)) r = s[VAL_W-1:0];
    else if (s[ACC_W-17])  r = 32'sh8000_0000;
    else                   r = 32'sh7FFF_FFFF;
    return r;
  endfunction

  // Advance the stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      l1   <= 1'b0;
      v2   <= 1'b0;
      l2   <= 1'b0;
      l3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= ctl.issue;
      l1   <= ctl.issue && ctl.last;
      v2   <= v1;
      l2   <= l1;
      l3   <= v2 && l2;
      done <= l3;
    end
  end

  // Multiply, accumulate, round
  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= a_data * d_data;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (l3) begin
      value <= round_sat(acc);
    end
  end

  assign res.done  = done;
  assign res.value = value;

endmodule

// ===== sv/bdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdm_ctrl
// Sequencer: configuration registers, request decode and range checks,
// store writes, query read walk and the result register.
// ----------------------------------------------------------------------------
module bdm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [3:0]                  cfg_data,
  bdm_req_if.sink                     req,
  bdm_res_if.source                   res,
  output logic                        blk_we,
  output logic [bdm_pkg::BLK_AW-1:0]  blk_waddr,
  output logic [bdm_pkg::BLK_AW-1:0]  blk_raddr,
  output logic                        dns_we,
  output logic [bdm_pkg::DNS_AW-1:0]  dns_waddr,
  output logic [bdm_pkg::DNS_AW-1:0]  dns_raddr,
  output bdm_pkg::mac_ctl_t           mac_ctl,
  input  bdm_pkg::mac_res_t           mac_res
);
  import bdm_pkg::*;

  state_t state, state_next;

  logic [REG_W-1:0] block_rows, block_cols, block_count, dense_cols;
  logic [REG_W-1:0] nr, nc, nb, dc;
  logic [IDX_W:0]   rows_lim, drows_lim;

  logic [IDX_W-1:0]  q_row;
  logic [DCOL_W-1:0] q_col;
  logic [BIDX_W-1:0] q_blk;
  logic [BCOL_W-1:0] j;
  logic              j_last;

  logic [VAL_W-1:0]  res_value;
  logic              res_status;
  logic              out_valid;
  logic [VAL_W-1:0]  out_value;
  logic              out_status;

  logic accept, blk_ok, dns_ok, qry_ok, cmd_ok, out_free;
  cmd_t cmd;

  logic [BIDX_W:0]   quot;
  logic [IDX_W:0]    i_full;
  logic [IDX_W:0]    drow_full;

  // Effective register values
  assign nr = eff(block_rows,  REG_W'(MAX_BLOCK_ROWS));
  assign nc = eff(block_cols,  REG_W'(MAX_BLOCK_COLS));
  assign nb = eff(block_count, REG_W'(MAX_BLOCKS));
  assign dc = eff(dense_cols,  REG_W'(MAX_DENSE_COLS));
  assign rows_lim  = (IDX_W+1)'(nr * nb);
  assign drows_lim = (IDX_W+1)'(nc * nb);

  // Decode and range checks
  assign cmd    = cmd_t'(req.cmd);
  assign blk_ok = ({1'b0, req.block_index} < nb) &&
                  (req.row_index < IDX_W'(nr)) && (req.col_index < IDX_W'(nc));
  assign dns_ok = ({1'b0, req.row_index} < drows_lim) && (req.col_index < IDX_W'(dc));
  assign qry_ok = ({1'b0, req.row_index} < rows_lim)  && (req.col_index < IDX_W'(dc));

  always_comb begin
    unique case (cmd)
      CMD_LOAD_BLOCK: cmd_ok = blk_ok;
      CMD_LOAD_DENSE: cmd_ok = dns_ok;
      CMD_QUERY:      cmd_ok = qry_ok;
      default:        cmd_ok = 1'b0;
    endcase
  end

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;

  // Block number of a query row: count the block boundaries at or below it
  always_comb begin
    quot = '0;
    for (int m = 1; m < MAX_BLOCKS; m++) begin
      if ((IDX_W+1)'(m * nr) <= {1'b0, q_row}) quot = quot + (BIDX_W+1)'(1);
    end
  end

  // Row within block and dense row of the current walk step
  assign i_full    = {1'b0, q_row} - (IDX_W+1)'(q_blk * nr);
  assign drow_full = (IDX_W+1)'(j) + (IDX_W+1)'(nc * q_blk);
  assign j_last    = ({1'b0, j} == nc - REG_W'(1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_rows  <= REG_W'(MAX_BLOCK_ROWS);
      block_cols  <= REG_W'(MAX_BLOCK_COLS);
      block_count <= REG_W'(MAX_BLOCKS);
      dense_cols  <= REG_W'(MAX_DENSE_COLS);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_ROWS:  block_rows  <= cfg_data;
        REG_BLOCK_COLS:  block_cols  <= cfg_data;
        REG_BLOCK_COUNT: block_count <= cfg_data;
        REG_DENSE_COLS:  dense_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        state_next = (cmd == CMD_QUERY && qry_ok) ? S_DIV : S_PUSH;
      end
      S_DIV:  state_next = S_RUN;
      S_RUN:  if (j_last) state_next = S_WAIT;
      S_WAIT: if (mac_res.done) state_next = S_PUSH;
      S_PUSH: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready     = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.issue = 1'b0;
    mac_ctl.last  = 1'b0;
    unique case (state)
      S_IDLE: req.ready     = 1'b1;
      S_DIV:  mac_ctl.clear = 1'b1;
      S_RUN: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.last  = j_last;
      end
      S_WAIT, S_PUSH: ;
      default: ;
    endcase
  end

  // Store write and read ports
  assign blk_we    = accept && (cmd == CMD_LOAD_BLOCK) && blk_ok;
  assign blk_waddr = {req.block_index[BIDX_W-1:0], req.row_index[BROW_W-1:0],
                      req.col_index[BCOL_W-1:0]};
  assign dns_we    = accept && (cmd == CMD_LOAD_DENSE) && dns_ok;
  assign dns_waddr = {req.row_index[DROW_W-1:0], req.col_index[DCOL_W-1:0]};
  assign blk_raddr = {q_blk, i_full[BROW_W-1:0], j};
  assign dns_raddr = {drow_full[DROW_W-1:0], q_col};

  // Hold the request and walk the block columns
  always_ff @(posedge clk) begin
    if (accept) begin
      q_row      <= req.row_index;
      q_col      <= req.col_index[DCOL_W-1:0];
      res_value  <= '0;
      res_status <= !cmd_ok;
    end
    if (state == S_DIV) begin
      q_blk <= quot[BIDX_W-1:0];
      j     <= '0;
    end else if (state == S_RUN) begin
      j     <= j + BCOL_W'(1);
    end
    if (state == S_WAIT && mac_res.done) begin
      res_value <= mac_res.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign res.valid         = out_valid;
  assign res.product_value = out_value;
  assign res.status        = out_status;

endmodule

// ===== sv/block_diagonal_times_dense_multiply_core.sv =====
// ----------------------------------------------------------------------------
// block_diagonal_times_dense_multiply_core
// Block-diagonal times dense matrix multiply in Q16.16, element by element,
// with both operands held in on-chip stores.
// ----------------------------------------------------------------------------
//  Channel | Dir | Carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | cmd, block_index, row_index, col_index, element_value
//  res     | out | product_value, status (one result per request)
//  cfg     | in  | cfg_we, cfg_index, cfg_data (block_rows/cols/count, dense_cols)
//
//  A load or a rejected request goes from the accept to S_PUSH and then into
//  the result register. A query reads once per block column from the two
//  stores, then passes the multiply, accumulate and rounding stages.
//  One request is in flight at a time; the result register lets the next
//  request be accepted while the previous result waits on res.ready.
//  Reset (rst, synchronous) restores the registers to 8; the stores are not
//  cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module block_diagonal_times_dense_multiply_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  bdm_req_if.sink    req,
  bdm_res_if.source  res
);
  import bdm_pkg::*;

  logic              blk_we, dns_we;
  logic [BLK_AW-1:0] blk_waddr, blk_raddr;
  logic [DNS_AW-1:0] dns_waddr, dns_raddr;
  logic [VAL_W-1:0]  blk_rdata, dns_rdata;
  mac_ctl_t          mac_ctl;
  mac_res_t          mac_res;

  bdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .res       (res),
    .blk_we    (blk_we),
    .blk_waddr (blk_waddr),
    .blk_raddr (blk_raddr),
    .dns_we    (dns_we),
    .dns_waddr (dns_waddr),
    .dns_raddr (dns_raddr),
    .mac_ctl   (mac_ctl),
    .mac_res   (mac_res)
  );

  // Block-diagonal operand store
  bdm_ram #(.DEPTH(BLK_DEPTH), .WIDTH(VAL_W)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (req.element_value),
    .re    (mac_ctl.issue),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  // Dense operand store
  bdm_ram #(.DEPTH(DNS_DEPTH), .WIDTH(VAL_W)) u_dns_ram (
    .clk   (clk),
    .we    (dns_we),
    .waddr (dns_waddr),
    .wdata (req.element_value),
    .re    (mac_ctl.issue),
    .raddr (dns_raddr),
    .rdata (dns_rdata)
  );

  bdm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_data (blk_rdata),
    .d_data (dns_rdata),
    .res    (mac_res)
  );

endmodule

// ===== sv/bdm_check.sv =====
// ----------------------------------------------------------------------------
// bdm_check
// Port-level checks of the multiply core, attached to the top level.
// ----------------------------------------------------------------------------
module bdm_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_product_value,
  input logic        res_status
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_product_value) && $stable(res_status))
    else $error("stalled result changed");

  // One request in flight: no accept in the cycle after an accept
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // An error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_product_value == 32'd0)
    else $error("error result with nonzero value");

endmodule

bind block_diagonal_times_dense_multiply_core bdm_check u_bdm_check (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_product_value (res.product_value),
  .res_status        (res.status)
);
